// ===== src/mavg_pkg.sv =====
// Shared types and constants for the moving average pressure block.
`default_nettype none

package mavg_pkg;

    localparam int CODE_W  = 10;
    localparam int GAIN_W  = 16;
    localparam int PRESS_W = 16;
    localparam int CFG_W   = 16;

    localparam logic [CODE_W-1:0]  CLAMP_RESET  = 10'd613;
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd4761;
    localparam logic [PRESS_W-1:0] OFFSET_RESET = 16'hFC6E;

    typedef enum logic [1:0] {
        CFG_CLAMP_MAX = 2'd0,
        CFG_GAIN_Q16  = 2'd1,
        CFG_OFFSET_Q8 = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              full;
        logic [CODE_W-1:0] oldest;
    } ring_rd_t;

endpackage

`default_nettype wire

// ===== src/moving_average_pressure_sensor_top.sv =====
// Top level: clamp, ring, running sum, average and fixed-point pressure pipeline.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_stall, sample                | one raw sample per beat
//  out     | out_valid, out_stall, average_code,       | one result per input beat
//          | pressure_q8                               |
//  cfg     | cfg_we, cfg_index, cfg_data               | register writes, no wait
//
// One beat per cycle while in_stall is low; a taken sample's valid passes v1_reg to v4_reg, then out_valid.
// The ring slot is read and written in the same cycle; the sum update is one add and subtract into sum_reg.
// Reset clears sum, ring position and fill count; ring contents need no clear.
// out_stall with a result pending freezes the whole pipe and raises in_stall.
`default_nettype none

module moving_average_pressure_sensor_top #(
    parameter int AVG_DEPTH   = 16,
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [mavg_pkg::CODE_W-1:0]        average_code,
    output logic signed [mavg_pkg::PRESS_W-1:0] pressure_q8,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [mavg_pkg::CFG_W-1:0]    cfg_data
);
    import mavg_pkg::*;

    localparam int CMP_W   = (SAMPLE_BITS > CODE_W) ? SAMPLE_BITS : CODE_W;
    localparam int SUM_W   = $clog2(AVG_DEPTH * 1023 + 1);
    localparam int DIV_K   = SUM_W + $clog2(AVG_DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int MUL_W   = CODE_W + GAIN_W;
    localparam int SCL_W   = MUL_W - 8;
    localparam int P_W     = SCL_W + 2;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << DIV_K) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    logic [CODE_W-1:0]  clamp_max_reg;
    logic [GAIN_W-1:0]  gain_q16_reg;
    logic [PRESS_W-1:0] offset_q8_reg;

    logic adv;
    logic accept;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    logic [CMP_W-1:0]  samp_ext;
    logic [CODE_W-1:0] clamped;
    logic [CODE_W-1:0] s1_sample_reg;
    ring_rd_t          ring_rd;

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [PROD_W-1:0] quot_reg;
    logic [CODE_W-1:0] avg3;
    logic [CODE_W-1:0] avg4_reg;
    logic [MUL_W-1:0]  mult_reg;

    logic [SCL_W-1:0]      scaled;
    logic signed [P_W-1:0] p_full;
    logic [PRESS_W-1:0]    p_sat;
    logic [CODE_W-1:0]     average_code_reg;
    logic [PRESS_W-1:0]    pressure_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_max_reg <= CLAMP_RESET;
            gain_q16_reg  <= GAIN_RESET;
            offset_q8_reg <= OFFSET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLAMP_MAX: clamp_max_reg <= cfg_data[CODE_W-1:0];
                CFG_GAIN_Q16:  gain_q16_reg  <= cfg_data[GAIN_W-1:0];
                CFG_OFFSET_Q8: offset_q8_reg <= cfg_data[PRESS_W-1:0];
                default:       ;
            endcase
        end
    end

    assign adv      = !(out_valid_reg && out_stall);
    assign accept   = in_valid && adv;
    assign in_stall = !adv;

    // stage 0: clamp and ring access
    assign samp_ext = CMP_W'(sample);
    assign clamped  = (samp_ext > CMP_W'(clamp_max_reg)) ? clamp_max_reg
                                                        : samp_ext[CODE_W-1:0];

    mavg_ring #(
        .AVG_DEPTH(AVG_DEPTH)
    ) u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_data(clamped),
        .rd     (ring_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
        end
        else if (adv)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
            if (v1_reg)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    // stage 1: running sum
    assign sum_next = sum_reg + SUM_W'(s1_sample_reg)
                    - (ring_rd.full ? SUM_W'(ring_rd.oldest) : '0);

    // stage 3 quotient bits
    assign avg3 = quot_reg[DIV_K +: CODE_W];

    // stage 4: scale, offset, saturate
    assign scaled = mult_reg[MUL_W-1:8];
    assign p_full = $signed({2'b00, scaled})
                  + $signed({{(P_W-PRESS_W){offset_q8_reg[PRESS_W-1]}}, offset_q8_reg});

    always_comb
    begin
        if (p_full > $signed(P_W'(32767)))
        begin
            p_sat = 16'h7FFF;
        end
        else if (p_full < -$signed(P_W'(32768)))
        begin
            p_sat = 16'h8000;
        end
        else
        begin
            p_sat = p_full[PRESS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                s1_sample_reg <= clamped;
            end
            if (v2_reg)
            begin
                quot_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
            end
            if (v3_reg)
            begin
                avg4_reg <= avg3;
                mult_reg <= MUL_W'(avg3) * MUL_W'(gain_q16_reg);
            end
            if (v4_reg)
            begin
                average_code_reg <= avg4_reg;
                pressure_reg     <= p_sat;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign average_code = average_code_reg;
    assign pressure_q8  = $signed(pressure_reg);

endmodule

`default_nettype wire

// ===== src/mavg_ring.sv =====
// Sample ring: one slot read (oldest) and written (newest) per beat, plus fill tracking.
`default_nettype none

module mavg_ring #(
    parameter int AVG_DEPTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [mavg_pkg::CODE_W-1:0] wr_data,
    output mavg_pkg::ring_rd_t             rd
);
    import mavg_pkg::*;

    localparam int PW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int FW = $clog2(AVG_DEPTH + 1);

    logic [CODE_W-1:0] mem [AVG_DEPTH];
    logic [PW-1:0]     pos_reg;
    logic [PW-1:0]     pos_next;
    logic [FW-1:0]     fill_reg;
    logic [FW-1:0]     fill_next;
    logic              full;
    logic              full_reg;
    logic [CODE_W-1:0] oldest_reg;

    assign full = (fill_reg == FW'(AVG_DEPTH));

    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (wr_en)
        begin
            pos_next = (pos_reg == PW'(AVG_DEPTH - 1)) ? '0 : pos_reg + PW'(1);
            if (!full)
            begin
                fill_next = fill_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            if (wr_en)
            begin
                full_reg <= full;
            end
        end
    end

    // read returns the old slot contents while the new sample lands
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            oldest_reg   <= mem[pos_reg];
            mem[pos_reg] <= wr_data;
        end
    end

    assign rd = '{full: full_reg, oldest: oldest_reg};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(AVG_DEPTH))
        else $error("fill count above depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !full |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("fill count did not advance");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> full_reg == $past(full))
        else $error("full flag does not match fill count");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < AVG_DEPTH)
        else $error("ring position out of range");
`endif

endmodule

`default_nettype wire

// ===== bench/moving_average_pressure_sensor_checker.sv =====
// Checker: tracks register writes, predicts each average and pressure, compares results.
`default_nettype none

module moving_average_pressure_sensor_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_stall,
    input  wire logic [mavg_pkg::CODE_W-1:0]         sample,
    input  wire logic                                out_valid,
    input  wire logic                                out_stall,
    input  wire logic [mavg_pkg::CODE_W-1:0]         average_code,
    input  wire logic signed [mavg_pkg::PRESS_W-1:0] pressure_q8,
    input  wire logic                                cfg_we,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [mavg_pkg::CFG_W-1:0]          cfg_data,
    output int                                       mismatches,
    output int                                       pending,
    output int                                       compared
);
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam int WINDOW = 16;

    typedef struct packed {
        logic [CODE_W-1:0]         avg;
        logic signed [PRESS_W-1:0] press;
    } reading_t;

    logic [CODE_W-1:0]         clamp_max;
    logic [GAIN_W-1:0]         gain_q16;
    logic signed [PRESS_W-1:0] offset_q8;

    logic [CODE_W-1:0] window_ring [WINDOW];
    logic [13:0]       window_sum;
    logic [3:0]        write_slot;
    logic [4:0]        held;

    reading_t expected_readings [$];

    function automatic reading_t advance_window(input logic [CODE_W-1:0] raw);
        logic [CODE_W-1:0] kept;
        logic [25:0]       scaled;
        longint            p;
        reading_t          r;
        kept = (raw > clamp_max) ? clamp_max : raw;
        if (held == 5'(WINDOW))
            window_sum = window_sum - 14'(window_ring[write_slot]);
        else
            held = held + 5'd1;
        window_ring[write_slot] = kept;
        window_sum = window_sum + 14'(kept);
        write_slot = write_slot + 4'd1;
        r.avg = window_sum[13:4];
        scaled = {16'd0, r.avg} * {10'd0, gain_q16};
        p = longint'(scaled[25:8]) + longint'(offset_q8);
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        r.press = 16'(p);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            clamp_max  = CLAMP_RESET;
            gain_q16   = GAIN_RESET;
            offset_q8  = OFFSET_RESET;
            window_sum = '0;
            write_slot = '0;
            held       = '0;
            expected_readings.delete();
            mismatches = 0;
            compared   = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLAMP_MAX: clamp_max = cfg_data[CODE_W-1:0];
                    CFG_GAIN_Q16:  gain_q16  = cfg_data;
                    CFG_OFFSET_Q8: offset_q8 = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_readings.push_back(advance_window(sample));
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: avg=%0d press=%0d",
                                 $realtime, average_code, pressure_q8);
                end
                else
                begin
                    want = expected_readings.pop_front();
                    compared++;
                    if (average_code !== want.avg || pressure_q8 !== want.press)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] result %0d: avg exp %0d got %0d, press exp %0d got %0d",
                                     $realtime, compared, want.avg, average_code,
                                     want.press, pressure_q8);
                    end
                end
            end
            pending = expected_readings.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/moving_average_pressure_sensor_top_tb.sv =====
// Testbench top: drives samples, register writes and output back-pressure, gives the verdict.
`default_nettype none

module moving_average_pressure_sensor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mavg_pkg::*;

    localparam int         LIMIT_CYCLES = 1_000_000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         RANDOM_ITEMS = 1950;
    localparam logic [1:0] CFG_SPARE    = 2'd3;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [CODE_W-1:0]    sample    = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    wire logic                      in_stall;
    wire logic                      out_valid;
    wire logic [CODE_W-1:0]         average_code;
    wire logic signed [PRESS_W-1:0] pressure_q8;

    int mismatches;
    int pending;
    int compared;

    bit                hold_req  = 1'b0;
    bit                quiet     = 1'b0;
    int                cycles    = 0;
    int                sent      = 0;
    int                settings  = 1;
    logic [CODE_W-1:0] cur_clamp = CLAMP_RESET;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    moving_average_pressure_sensor_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average_code (average_code),
        .pressure_q8  (pressure_q8),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    moving_average_pressure_sensor_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .average_code (average_code),
        .pressure_q8  (pressure_q8),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .compared     (compared)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_sample(input logic [CODE_W-1:0] v, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [CODE_W-1:0] clamp,
                                input logic [GAIN_W-1:0] gain,
                                input logic [PRESS_W-1:0] offset);
        logic [CFG_W-CODE_W-1:0] junk;
        junk = (CFG_W-CODE_W)'($urandom);
        cfg_write(CFG_CLAMP_MAX, {junk, clamp});
        cfg_write(CFG_GAIN_Q16, gain);
        cfg_write(CFG_OFFSET_Q8, offset);
        cfg_write(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_clamp = clamp;
        settings++;
    endtask

    // drain the pipe before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int n;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [CODE_W-1:0] warmup [18];
        logic [CODE_W-1:0] s;
        int                random_sent;
        int                phase;
        int                len;
        int                r;
        int                near;

        warmup = '{10'd0, 10'd1023, 10'd613, 10'd614, 10'd612, 10'd1, 10'd2, 10'd4,
                   10'd8, 10'd16, 10'd32, 10'd64, 10'd128, 10'd256, 10'd512,
                   10'd341, 10'd682, 10'd1023};
        random_sent = 0;
        phase       = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, warm-up ramp and clamping at the reset maximum
        foreach (warmup[i])
            send_sample(warmup[i], pick_gap());

        // full scale: high saturation of pressure
        settle();
        program_regs(10'd1023, 16'hFFFF, 16'h7FFF);
        repeat (4) send_sample(10'd1023, pick_gap());

        // everything clamps to zero, lowest offset
        settle();
        program_regs(10'd0, 16'h0000, 16'h8000);
        send_sample(10'd1023, 0);
        send_sample(10'd700, 0);

        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            if (phase > 0)
            begin
                logic [CODE_W-1:0]  c;
                logic [GAIN_W-1:0]  g;
                logic [PRESS_W-1:0] o;
                r = $urandom_range(0, 19);
                c = (r < 3) ? 10'd1023 : (r < 4) ? 10'd0 : 10'($urandom);
                r = $urandom_range(0, 19);
                g = (r < 2) ? 16'hFFFF : (r < 3) ? 16'h0000 : 16'($urandom);
                r = $urandom_range(0, 19);
                o = (r < 2) ? 16'h7FFF : (r < 3) ? 16'h8000 : 16'($urandom);
                program_regs(c, g, o);
            end
            quiet = (phase % 4 == 2);
            if (phase == 5)
            begin
                quiet    = 1'b1;
                hold_req = 1'b1;
            end
            len = $urandom_range(30, 150);
            if (len > RANDOM_ITEMS - random_sent)
                len = RANDOM_ITEMS - random_sent;
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 19);
                if (r < 12)
                    s = 10'($urandom_range(0, 1023));
                else if (r < 15)
                begin
                    near = int'(cur_clamp) + $urandom_range(0, 4) - 2;
                    near = (near < 0) ? 0 : (near > 1023) ? 1023 : near;
                    s = 10'(near);
                end
                else if (r < 17)
                    s = 10'd1023;
                else if (r < 18)
                    s = 10'd0;
                else
                    s = 10'($urandom_range(0, 15));
                send_sample(s, quiet ? 0 : pick_gap());
                random_sent++;
            end
            quiet = 1'b0;
            phase++;
        end

        settle();
        repeat (12) @(negedge clk);

        $display("Run covered %0d samples under %0d register settings, %0d results compared.",
                 sent, settings, compared);
        if (pending != 0)
            $display("%0d results never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
